>>> src/assert_macros.svh
// Assertion macros used by the wake-up trigger table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define WTT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wake-up trigger table assertion failed");
// Clocked assertion that also holds during reset.
`define WTT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("wake-up trigger table assertion failed");
`else
`define WTT_ASSERT(lbl, clk, rst_n, prop)
`define WTT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/wtt_pkg.sv
// Package with the types and codes of the wake-up trigger table.
package wtt_pkg;

    localparam int IDX_W = 5;

    localparam logic [2:0] REQ_FIND    = 3'd0;
    localparam logic [2:0] REQ_ADD     = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_SET     = 3'd3;
    localparam logic [2:0] REQ_ACK     = 3'd4;
    localparam logic [2:0] REQ_QUERY   = 3'd5;
    localparam logic [2:0] REQ_ACK_ALL = 3'd6;
    localparam logic [2:0] REQ_CLEAR   = 3'd7;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_INVALID   = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0] cls;
        logic [4:0] num;
        logic [1:0] mst;
        logic [2:0] flg;
    } t_entry;

    // Request token that walks the cell chain and gathers search results.
    typedef struct packed {
        logic             valid;
        logic [2:0]       req;
        logic [1:0]       cls;
        logic [4:0]       num;
        logic [1:0]       mst;
        logic [2:0]       flg;
        logic [IDX_W-1:0] sel;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             pend;
    } t_token;

    // Entry write that the controller broadcasts after an add search.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_wr;

endpackage

>>> src/wtt_req_if.sv
// Request channel interface of the wake-up trigger table.
interface wtt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [1:0] trigger_class;
    logic [4:0] trigger_number;
    logic [1:0] wake_master;
    logic [2:0] resource_flags;
    logic [4:0] entry_select;

    modport source (
        output valid, req_type, trigger_class, trigger_number, wake_master,
               resource_flags, entry_select,
        input  ready
    );
    modport sink (
        input  valid, req_type, trigger_class, trigger_number, wake_master,
               resource_flags, entry_select,
        output ready
    );
endinterface

>>> src/wtt_rsp_if.sv
// Response channel interface of the wake-up trigger table.
interface wtt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] entry_index;
    logic       is_pending;

    modport source (
        output valid, status, entry_index, is_pending,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, is_pending,
        output ready
    );
endinterface

>>> src/wtt_cell.sv
// One table slot with its pending bit, acting on the token passing through.
module wtt_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wtt_pkg::t_token i_tok,
    input  wtt_pkg::t_wr    i_wr,
    output wtt_pkg::t_token o_tok
);

    localparam logic [wtt_pkg::IDX_W-1:0] MY_IDX = wtt_pkg::IDX_W'(CELL_INDEX);

    wtt_pkg::t_entry r_entry, n_entry;
    logic            r_pend, n_pend;
    wtt_pkg::t_token r_tok, n_tok;
    wtt_pkg::t_entry w_want;
    logic            w_sel_me;

    assign w_want   = '{cls: i_tok.cls, num: i_tok.num, mst: i_tok.mst, flg: i_tok.flg};
    assign w_sel_me = (i_tok.sel == MY_IDX);

    always_comb begin
        n_tok   = i_tok;
        n_entry = r_entry;
        n_pend  = r_pend;
        if (i_tok.valid) begin
            case (i_tok.req)
                wtt_pkg::REQ_FIND: begin
                    if (!i_tok.found && r_entry.mst != 2'd0 && r_entry.cls == i_tok.cls &&
                        r_entry.num == i_tok.num && r_entry.mst == i_tok.mst) begin
                        n_tok.found = 1'b1;
                        n_tok.idx   = MY_IDX;
                    end
                end
                wtt_pkg::REQ_ADD: begin
                    if (!i_tok.found && r_entry == w_want) begin
                        n_tok.found = 1'b1;
                        n_tok.idx   = MY_IDX;
                    end
                    if (!i_tok.free_found && r_entry.mst == 2'd0) begin
                        n_tok.free_found = 1'b1;
                        n_tok.free_idx   = MY_IDX;
                    end
                end
                wtt_pkg::REQ_REMOVE: begin
                    if (w_sel_me) begin
                        n_entry = '0;
                        n_pend  = 1'b0;
                    end
                end
                wtt_pkg::REQ_SET: begin
                    if (w_sel_me) n_pend = 1'b1;
                end
                wtt_pkg::REQ_ACK: begin
                    if (w_sel_me) n_pend = 1'b0;
                end
                wtt_pkg::REQ_QUERY: begin
                    if (w_sel_me) n_tok.pend = r_pend;
                end
                wtt_pkg::REQ_ACK_ALL: begin
                    n_pend = 1'b0;
                end
                default: begin
                    n_entry = '0;
                    n_pend  = 1'b0;
                end
            endcase
        end
        if (i_wr.en && i_wr.idx == MY_IDX) begin
            n_entry = i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_pend      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
            r_pend  <= n_pend;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> src/wakeup_trigger_table_top.sv
// Top level of the wake-up trigger table: controller and chain of slot cells.
// Path: the request token register, each slot cell's register, the result register and the
// output register, which waits while an earlier response is not taken. A request is accepted
// only when idle, once the last result is stored; the token steps one slot cell per cycle.
// Reset: synchronous, active low; it frees every slot and clears all pending bits at once,
// so the first request can be taken in the cycle after reset is released.
`include "assert_macros.svh"

module wakeup_trigger_table_top #(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wtt_req_if.sink      i_req,
    wtt_rsp_if.source    o_rsp
);

    // The controller takes one request at a time. The request becomes a token
    // that enters slot cell 0 and moves one cell down the chain each cycle. Every
    // cell acts on the token: it updates its own slot for index-addressed and
    // global requests, and it marks the token with its index when it holds the
    // first matching, identical or free slot.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state          r_state;
    wtt_pkg::t_token r_tok;
    wtt_pkg::t_token w_new_tok;
    wtt_pkg::t_token w_tok [0:ENTRIES];
    logic [ENTRIES-1:0] w_tok_valid;
    wtt_pkg::t_token w_end;
    wtt_pkg::t_wr    r_wr;
    wtt_pkg::t_wr    n_wr;

    logic [1:0]                r_res_status, n_res_status;
    logic [wtt_pkg::IDX_W-1:0] r_res_idx,    n_res_idx;
    logic                      r_res_pend,   n_res_pend;

    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [wtt_pkg::IDX_W-1:0] r_out_idx;
    logic                      r_out_pend;

    assign w_new_tok = '{
        valid:      1'b1,
        req:        i_req.req_type,
        cls:        i_req.trigger_class,
        num:        i_req.trigger_number,
        mst:        i_req.wake_master,
        flg:        i_req.resource_flags,
        sel:        i_req.entry_select,
        found:      1'b0,
        idx:        '0,
        free_found: 1'b0,
        free_idx:   '0,
        pend:       1'b0
    };

    assign w_tok[0] = r_tok;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        wtt_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_wr    (r_wr),
            .o_tok   (w_tok[g+1])
        );
        assign w_tok_valid[g] = w_tok[g+1].valid;
    end

    assign w_end = w_tok[ENTRIES];

    // Result of the request once its token has left the last cell. An add with a nonzero
    // wake master that found no identical slot writes the first free slot, if any, through r_wr.
    always_comb begin
        n_res_status = wtt_pkg::STS_OK;
        n_res_idx    = '0;
        n_res_pend   = 1'b0;
        n_wr.en      = 1'b0;
        n_wr.idx     = w_end.free_idx;
        n_wr.entry   = '{cls: w_end.cls, num: w_end.num, mst: w_end.mst, flg: w_end.flg};
        case (w_end.req)
            wtt_pkg::REQ_FIND: begin
                if (w_end.found) begin
                    n_res_idx = w_end.idx;
                end else begin
                    n_res_status = wtt_pkg::STS_NOT_FOUND;
                end
            end
            wtt_pkg::REQ_ADD: begin
                if (w_end.mst == 2'd0) begin
                    n_res_status = wtt_pkg::STS_INVALID;
                end else if (w_end.found) begin
                    n_res_idx = w_end.idx;
                end else if (w_end.free_found) begin
                    n_res_idx = w_end.free_idx;
                    n_wr.en   = 1'b1;
                end else begin
                    n_res_status = wtt_pkg::STS_FULL;
                end
            end
            wtt_pkg::REQ_QUERY: begin
                n_res_pend = w_end.pend;
            end
            default: begin
                n_res_status = wtt_pkg::STS_OK;
            end
        endcase
    end

    // State and registered outputs. The output register holds a finished
    // result until it is taken, while the next transaction already runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tok.valid <= 1'b0;
            r_wr.en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tok.valid <= 1'b0;
            r_wr.en     <= 1'b0;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_tok   <= w_new_tok;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_end.valid) begin
                        r_res_status <= n_res_status;
                        r_res_idx    <= n_res_idx;
                        r_res_pend   <= n_res_pend;
                        r_wr         <= n_wr;
                        r_state      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_idx    <= r_res_idx;
                        r_out_pend   <= r_res_pend;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // No request is taken while reset is asserted.
    assign i_req.ready       = (r_state == ST_IDLE) && i_rst_n;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.is_pending  = r_out_pend;

    // Only one token may be in the cell chain at any time.
    `WTT_ASSERT(a_one_token, i_clk, i_rst_n, $countones(w_tok_valid) <= 1)
    // A token leaves the chain only while the controller waits for it.
    `WTT_ASSERT(a_end_in_scan, i_clk, i_rst_n, w_end.valid |-> r_state == ST_SCAN)
    // A slot write follows the end of an add search and never overlaps a token.
    `WTT_ASSERT(a_wr_after_add, i_clk, i_rst_n,
        r_wr.en |-> (r_state == ST_DONE && w_tok_valid == '0 && !r_tok.valid))

endmodule
